>>> src/svptw_pkg.sv
// Shared types and constants for the Sv39 page table walker.
// Used by every module of the walker; depends on nothing.
`default_nettype none

package svptw_pkg;

	localparam int unsigned TABLE_FRAMES = 8;
	localparam int unsigned WALK_LEVELS = 3;
	localparam int unsigned ENTRIES = 512;
	localparam int unsigned STORE_WORDS = TABLE_FRAMES * ENTRIES;
	localparam int unsigned STORE_AW = $clog2(STORE_WORDS);
	localparam int unsigned FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;

	localparam int unsigned PPN_W = 44;
	localparam int unsigned VA_W = 39;
	localparam int unsigned PA_W = 56;
	localparam int unsigned PTE_W = 64;
	localparam int unsigned WIDX_W = 12;
	localparam int unsigned VPN_W = 9;
	localparam int unsigned PAGE_W = 12;
	localparam int unsigned VPNS_W = VA_W - PAGE_W;
	localparam int unsigned LVL_W = 2;

	localparam int unsigned PTE_V = 0;
	localparam int unsigned PTE_R = 1;
	localparam int unsigned PTE_X = 3;
	localparam int unsigned PTE_U = 4;
	localparam int unsigned PTE_PPN_LSB = 10;

	localparam logic [LVL_W-1:0] LVL_ROOT = LVL_W'(WALK_LEVELS - 1);
	localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
	localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_XLATE = 1'b1;

	localparam int unsigned CFG_AW = 4;
	localparam int unsigned CFG_DW = 64;
	localparam int unsigned CFG_SEL_BIT = 3;
	localparam logic REG_ROOT_PPN = 1'b0;
	localparam logic REG_BASE_PPN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_EVAL,
		ST_SUPER,
		ST_DONE
	} walk_state_t;

	typedef struct packed {
		logic sub;
		logic [PPN_W-1:0] a;
		logic [PPN_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [PPN_W-1:0] y;
		logic borrow;
	} alu_rsp_t;

	typedef struct packed {
		logic wr_en;
		logic [STORE_AW-1:0] wr_addr;
		logic [PTE_W-1:0] wdata;
		logic rd_en;
		logic [STORE_AW-1:0] rd_addr;
	} store_req_t;

	typedef struct packed {
		logic [PA_W-1:0] phys_addr;
		logic fault;
		logic leaf_level;
	} walk_res_t;

endpackage

`default_nettype wire

>>> src/svptw_store.sv
// Page table store: single write port and one read port with registered data.
// Depends on svptw_pkg.
`default_nettype none

module svptw_store (
	input wire logic clk,
	input wire svptw_pkg::store_req_t req,
	output logic [svptw_pkg::PTE_W-1:0] rdata
);
	import svptw_pkg::*;

	logic [PTE_W-1:0] mem_q [STORE_WORDS];
	logic [PTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/svptw_alu.sv
// Shared 44-bit adder and subtractor of the walker.
// Depends on svptw_pkg.
`default_nettype none

module svptw_alu (
	input wire svptw_pkg::alu_req_t req,
	output svptw_pkg::alu_rsp_t rsp
);
	import svptw_pkg::*;

	logic [PPN_W-1:0] b_eff;
	logic [PPN_W:0] sum;

	always_comb begin
		b_eff = req.sub ? ~req.b : req.b;
		sum = {1'b0, req.a} + {1'b0, b_eff} + (PPN_W+1)'(req.sub);
		rsp.y = sum[PPN_W-1:0];
		rsp.borrow = req.sub & ~sum[PPN_W];
	end

endmodule

`default_nettype wire

>>> src/svptw_walker.sv
// Walk sequencer: takes items, drives the store and the shared adder level by level.
// Depends on svptw_pkg.
`default_nettype none

module svptw_walker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic mode,
	input wire logic [svptw_pkg::WIDX_W-1:0] word_index,
	input wire logic [svptw_pkg::PTE_W-1:0] pte_word,
	input wire logic [svptw_pkg::VA_W-1:0] virt_addr,
	input wire logic [svptw_pkg::PPN_W-1:0] root_ppn,
	input wire logic [svptw_pkg::PPN_W-1:0] base_ppn,
	output svptw_pkg::alu_req_t alu_req,
	input wire svptw_pkg::alu_rsp_t alu_rsp,
	output svptw_pkg::store_req_t st_req,
	input wire logic [svptw_pkg::PTE_W-1:0] st_rdata,
	output logic res_valid,
	input wire logic res_ready,
	output svptw_pkg::walk_res_t res
);
	import svptw_pkg::*;

	walk_state_t state_q, state_d;
	logic [LVL_W-1:0] level_q;
	logic [PPN_W-1:0] ppn_q;
	logic [VPNS_W-1:0] vpns_q;
	walk_res_t res_q;

	logic accept;
	logic wr_in_range;
	logic [VPN_W-1:0] vpn_cur;
	logic frame_ok;
	logic pte_v, pte_u, pte_leaf;
	logic eval_fault, eval_next, eval_super;
	logic [PPN_W-1:0] pte_ppn;

	always_comb begin
		unique case (level_q)
			2'd2: vpn_cur = vpns_q[3*VPN_W-1:2*VPN_W];
			2'd1: vpn_cur = vpns_q[2*VPN_W-1:VPN_W];
			default: vpn_cur = vpns_q[VPN_W-1:0];
		endcase
	end

	assign accept = in_valid & in_ready;
	assign wr_in_range = 32'(word_index) < STORE_WORDS;
	assign frame_ok = ~alu_rsp.borrow & (alu_rsp.y < PPN_W'(TABLE_FRAMES));

	assign pte_v = st_rdata[PTE_V];
	assign pte_u = st_rdata[PTE_U];
	assign pte_leaf = (level_q == LVL_LEAF) | st_rdata[PTE_R] | st_rdata[PTE_X];
	assign pte_ppn = st_rdata[PTE_PPN_LSB +: PPN_W];
	assign eval_fault = ~pte_v | (pte_leaf & ((level_q == LVL_ROOT) | ~pte_u));
	assign eval_next = pte_v & ~pte_leaf;
	assign eval_super = ~eval_fault & pte_leaf & (level_q == LVL_MID);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_WRITE || virt_addr[VA_W-1]) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_ADDR;
					end
				end
			end
			ST_ADDR: state_d = frame_ok ? ST_EVAL : ST_DONE;
			ST_EVAL: begin
				priority if (eval_fault) begin
					state_d = ST_DONE;
				end else if (eval_next) begin
					state_d = ST_ADDR;
				end else if (eval_super) begin
					state_d = ST_SUPER;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SUPER: state_d = ST_DONE;
			ST_DONE: state_d = res_ready ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res = res_q;
		alu_req.sub = (state_q != ST_SUPER);
		alu_req.a = ppn_q;
		alu_req.b = (state_q == ST_SUPER) ? PPN_W'(vpns_q[VPN_W-1:0]) : base_ppn;
		st_req.wr_en = accept & (mode == MODE_WRITE) & wr_in_range;
		st_req.wr_addr = STORE_AW'(word_index);
		st_req.wdata = pte_word;
		st_req.rd_en = (state_q == ST_ADDR) & frame_ok;
		st_req.rd_addr = STORE_AW'({alu_rsp.y[FRAME_W-1:0], vpn_cur});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= LVL_ROOT;
		end else begin
			state_q <= state_d;
			if (accept) begin
				level_q <= LVL_ROOT;
			end else if (state_q == ST_EVAL && eval_next) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vpns_q <= virt_addr[VA_W-1:PAGE_W];
					ppn_q <= root_ppn;
					res_q.phys_addr <= '0;
					res_q.leaf_level <= 1'b0;
					res_q.fault <= (mode == MODE_XLATE);
				end
			end
			ST_ADDR: begin
				res_q.fault <= 1'b1;
			end
			ST_EVAL: begin
				if (eval_next || eval_super) begin
					ppn_q <= pte_ppn;
				end else if (!eval_fault) begin
					res_q.phys_addr <= {pte_ppn, PAGE_W'(0)};
					res_q.fault <= 1'b0;
					res_q.leaf_level <= 1'b0;
				end
			end
			ST_SUPER: begin
				res_q.phys_addr <= {alu_rsp.y, PAGE_W'(0)};
				res_q.fault <= 1'b0;
				res_q.leaf_level <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		st_req.rd_en |=> state_q == ST_EVAL)
		else $error("Store read was not followed by an evaluation cycle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR || state_q == ST_EVAL) |-> level_q != 2'd3)
		else $error("Walk level left the three Sv39 levels.");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUPER |-> $past(state_q) == ST_EVAL && $past(level_q) == LVL_MID)
		else $error("Superpage sum started without a level 1 leaf.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.fault) |-> (res.phys_addr == '0 && !res.leaf_level))
		else $error("Faulting result carries an address or a superpage mark.");

endmodule

`default_nettype wire

>>> src/sv39_page_table_walk.sv
// Top level of the Sv39 page table walker: stream ports, register port, output register.
// Depends on svptw_pkg, svptw_walker, svptw_alu and svptw_store.
//
// The walker takes one item at a time; s_tready is high only while it is idle. A write
// item stores one PTE word, and its result, like that of an address at or above 2^38, is
// valid in the cycle after acceptance. A translation passes through ST_ADDR and ST_EVAL
// on each level it reads, since the store's read port returns registered data
// in the cycle after the shared adder has formed the frame address, and through ST_SUPER
// for a superpage, where the same adder forms the page inside the 2 MB region. A 4 KB
// page thus reads three levels and a superpage two, and the walker goes back to idle
// before the next item; an early fault ends the walk sooner. The result goes to an output
// register, so the walker takes the next item while an earlier result waits on m_tready.
`default_nettype none

module sv39_page_table_walk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// word_index [11:0], pte_word [75:12], virt_addr [114:76], zero fill [119:115]
	input wire logic [119:0] s_tdata,
	// mode [0]
	input wire logic [0:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// phys_addr [55:0]
	output logic [55:0] m_tdata,
	// fault [0], leaf_level [1]
	output logic [1:0] m_tuser,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [svptw_pkg::CFG_AW-1:0] paddr,
	input wire logic [svptw_pkg::CFG_DW-1:0] pwdata,
	output logic [svptw_pkg::CFG_DW-1:0] prdata,
	output logic pready
);
	import svptw_pkg::*;

	logic [PPN_W-1:0] root_ppn_q;
	logic [PPN_W-1:0] base_ppn_q;
	logic cfg_wr;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	store_req_t st_req;
	logic [PTE_W-1:0] st_rdata;
	logic res_valid;
	logic res_ready;
	walk_res_t res;

	logic out_valid_q;
	walk_res_t out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_ppn_q <= '0;
			base_ppn_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[CFG_SEL_BIT])
				REG_ROOT_PPN: root_ppn_q <= pwdata[PPN_W-1:0];
				REG_BASE_PPN: base_ppn_q <= pwdata[PPN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[CFG_SEL_BIT])
			REG_ROOT_PPN: prdata = CFG_DW'(root_ppn_q);
			REG_BASE_PPN: prdata = CFG_DW'(base_ppn_q);
			default: prdata = '0;
		endcase
	end

	svptw_walker u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.mode(s_tuser[0]),
		.word_index(s_tdata[WIDX_W-1:0]),
		.pte_word(s_tdata[WIDX_W +: PTE_W]),
		.virt_addr(s_tdata[WIDX_W+PTE_W +: VA_W]),
		.root_ppn(root_ppn_q),
		.base_ppn(base_ppn_q),
		.alu_req(alu_req),
		.alu_rsp(alu_rsp),
		.st_req(st_req),
		.st_rdata(st_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	svptw_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	svptw_store u_store (
		.clk(clk),
		.req(st_req),
		.rdata(st_rdata)
	);

	assign res_ready = ~out_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q.phys_addr;
	assign m_tuser = {out_q.leaf_level, out_q.fault};

endmodule

`default_nettype wire
